// ===== rtl/core/blae_pkg.sv =====
// Shared types and constants of the bounded array list engine.
package blae_pkg;

   // Store geometry and field widths.
   localparam int SLOTS  = 64;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int WORD_W = 32;
   localparam int CMD_W  = 4;
   localparam int POS_W  = 7;

   // Found position reported when no entry matches.
   localparam logic signed [POS_W-1:0] NOT_FOUND = '1;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_GET        = 4'd0,
      CMD_SET        = 4'd1,
      CMD_INS_LAST   = 4'd2,
      CMD_DEL_LAST   = 4'd3,
      CMD_INS_FIRST  = 4'd4,
      CMD_DEL_FIRST  = 4'd5,
      CMD_INS_AT     = 4'd6,
      CMD_DEL_AT     = 4'd7,
      CMD_FIND       = 4'd8
   } blae_cmd_type;

   // What every cell of the chain does with its word.
   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_WRITE,
      SHIFT_UP,
      SHIFT_DOWN
   } blae_shift_op_type;

   // Control broadcast from the decoder to every cell.
   typedef struct packed {
      blae_shift_op_type         op;
      logic [CNT_W-1:0]          at_pos;
      logic [CNT_W-1:0]          count;
      logic signed [WORD_W-1:0]  word;
      logic [IDX_W-1:0]          read_index;
   } blae_cell_ctrl_type;

endpackage

// ===== rtl/core/blae_req_if.sv =====
// Command channel of the bounded array list engine.
interface blae_req_if import blae_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [POS_W-1:0]          position;
   logic signed [WORD_W-1:0]  data_word;

   modport source (output valid, command, position, data_word, input ready);
   modport sink   (input valid, command, position, data_word, output ready);
endinterface

// ===== rtl/core/blae_rsp_if.sv =====
// Result channel of the bounded array list engine.
interface blae_rsp_if import blae_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  read_word;
   logic signed [POS_W-1:0]   found_position;
   logic                      rejected;
   logic [CNT_W-1:0]          entry_count;
   logic                      full_flag;
   logic                      empty_flag;

   modport source (output valid, read_word, found_position, rejected, entry_count,
                   full_flag, empty_flag, input ready);
   modport sink   (input valid, read_word, found_position, rejected, entry_count,
                   full_flag, empty_flag, output ready);
endinterface

// ===== rtl/core/blae_cell.sv =====
// One slot of the list: holds a word and shifts it to or from its neighbours.
module blae_cell import blae_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IDX_W-1:0]          cell_index,
   input  blae_cell_ctrl_type        ctrl,
   input  logic signed [WORD_W-1:0]  left_word,
   input  logic signed [WORD_W-1:0]  right_word,
   output logic signed [WORD_W-1:0]  cell_word,
   output logic signed [WORD_W-1:0]  read_word,
   output logic                      match
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic [CNT_W-1:0]         idx_ext;
   logic [CNT_W-1:0]         idx_next;

   assign idx_ext  = CNT_W'(cell_index);
   assign idx_next = idx_ext + CNT_W'(1);

   // Choose the next word: keep, load the command word, or take a neighbour's.
   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         SHIFT_WRITE: begin
            if (idx_ext == ctrl.at_pos) word_in = ctrl.word;
         end
         SHIFT_UP: begin
            if (idx_ext == ctrl.at_pos) begin
               word_in = ctrl.word;
            end else if (idx_ext > ctrl.at_pos && idx_ext <= ctrl.count) begin
               word_in = left_word;
            end
         end
         SHIFT_DOWN: begin
            if (idx_ext >= ctrl.at_pos && idx_next < ctrl.count) word_in = right_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // The store is cleared on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   // Drive the shared read bus only when addressed; match only inside the list.
   assign cell_word = word_ff;
   assign read_word = (cell_index == ctrl.read_index) ? word_ff : '0;
   assign match     = (word_ff == ctrl.word) && (idx_ext < ctrl.count);

endmodule

// ===== rtl/core/bounded_array_list_engine_unit.sv =====
// Top level of the bounded array list engine: decoder, cell chain and result register.
// The list lives in a chain of SLOTS cells, one word each, plus an entry count. Inserts
// and deletes move all affected words by one cell at once, find compares every cell in
// parallel and picks the lowest hit, and reads come over a shared bus. A new item is
// accepted in every cycle in which the result register is empty or its item is being
// taken, so the sustained rate is one item per clock.
// After reset the store reads as all zeros and the list is empty.
module bounded_array_list_engine_unit import blae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   blae_req_if.sink     req_chan,
   blae_rsp_if.source   rsp_chan
);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic signed [WORD_W-1:0]  read_word_ff;
   logic signed [POS_W-1:0]   found_ff;
   logic                      rejected_ff;
   logic [CNT_W-1:0]          rsp_count_ff;
   logic                      full_ff;
   logic                      empty_ff;

   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      pos_ok;
   logic [CNT_W-1:0]          pos_ext;
   logic                      rej;
   logic                      read_en;
   logic                      find_en;
   logic                      grows;
   logic [CNT_W-1:0]          count_next;
   blae_cell_ctrl_type        ctrl;
   blae_shift_op_type         op_sel;
   logic [CNT_W-1:0]          at_sel;
   logic [CNT_W-1:0]          read_sel;

   logic signed [WORD_W-1:0]  cell_words [SLOTS];
   logic signed [WORD_W-1:0]  left_words [SLOTS];
   logic signed [WORD_W-1:0]  right_words [SLOTS];
   logic signed [WORD_W-1:0]  bus_words [SLOTS];
   logic [SLOTS-1:0]          match_vec;
   logic [SLOTS-1:0]          lowest_hit;
   logic [IDX_W-1:0]          found_idx;
   logic signed [WORD_W-1:0]  read_bus;
   logic signed [POS_W-1:0]   found_pos;

   // Handshake: the result register parts the two sides.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full    = (count_ff == CNT_W'(SLOTS));
   assign empty   = (count_ff == '0);
   assign pos_ext = CNT_W'(req_chan.position);
   assign pos_ok  = (req_chan.position < POS_W'(SLOTS));

   // Decode the command into a cell operation, a read index and a new count.
   always_comb begin
      rej        = 1'b0;
      read_en    = 1'b0;
      find_en    = 1'b0;
      grows      = 1'b0;
      op_sel     = SHIFT_HOLD;
      at_sel     = pos_ext;
      read_sel   = pos_ext;
      count_next = count_ff;
      case (blae_cmd_type'(req_chan.command))
         CMD_GET: begin
            if (pos_ok) read_en = 1'b1; else rej = 1'b1;
         end
         CMD_SET: begin
            if (pos_ok) op_sel = SHIFT_WRITE; else rej = 1'b1;
         end
         CMD_INS_LAST: begin
            if (full) begin
               rej = 1'b1;
            end else begin
               op_sel     = SHIFT_UP;
               at_sel     = count_ff;
               grows      = 1'b1;
               count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL_LAST: begin
            if (empty) begin
               rej = 1'b1;
            end else begin
               read_en    = 1'b1;
               read_sel   = count_ff - CNT_W'(1);
               count_next = count_ff - CNT_W'(1);
            end
         end
         CMD_INS_FIRST: begin
            if (full) begin
               rej = 1'b1;
            end else begin
               op_sel     = SHIFT_UP;
               at_sel     = '0;
               grows      = 1'b1;
               count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL_FIRST: begin
            if (empty) begin
               rej = 1'b1;
            end else begin
               op_sel     = SHIFT_DOWN;
               at_sel     = '0;
               read_en    = 1'b1;
               read_sel   = '0;
               count_next = count_ff - CNT_W'(1);
            end
         end
         CMD_INS_AT: begin
            if (full || req_chan.position > POS_W'(count_ff)) begin
               rej = 1'b1;
            end else begin
               op_sel     = SHIFT_UP;
               grows      = 1'b1;
               count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_DEL_AT: begin
            if (empty || req_chan.position >= POS_W'(count_ff)) begin
               rej = 1'b1;
            end else begin
               op_sel     = SHIFT_DOWN;
               read_en    = 1'b1;
               count_next = count_ff - CNT_W'(1);
            end
         end
         CMD_FIND: begin
            find_en = 1'b1;
         end
         default: begin
            rej = 1'b1;
         end
      endcase
   end

   // Broadcast to the cells; they only move on an accepted item.
   always_comb begin
      ctrl.op         = accept ? op_sel : SHIFT_HOLD;
      ctrl.at_pos     = at_sel;
      ctrl.count      = count_ff;
      ctrl.word       = req_chan.data_word;
      ctrl.read_index = read_sel[IDX_W-1:0];
   end

   // The chain of cells, with neighbour links.
   for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
         assign left_words[gi] = '0;
      end else begin : g_inner_left
         assign left_words[gi] = cell_words[gi-1];
      end
      if (gi == SLOTS - 1) begin : g_last
         assign right_words[gi] = '0;
      end else begin : g_inner_right
         assign right_words[gi] = cell_words[gi+1];
      end
      blae_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(gi)),
         .ctrl       (ctrl),
         .left_word  (left_words[gi]),
         .right_word (right_words[gi]),
         .cell_word  (cell_words[gi]),
         .read_word  (bus_words[gi]),
         .match      (match_vec[gi])
      );
   end

   // Read bus: at most one cell drives a non-zero word.
   always_comb begin
      read_bus = '0;
      for (int i = 0; i < SLOTS; i++) begin
         read_bus = read_bus | bus_words[i];
      end
   end

   // Find: isolate the lowest matching cell and encode its index.
   assign lowest_hit = match_vec & (~match_vec + SLOTS'(1));
   always_comb begin
      found_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest_hit[i]) found_idx = found_idx | IDX_W'(i);
      end
   end
   assign found_pos = (find_en && (|match_vec)) ? POS_W'(found_idx) : NOT_FOUND;

   // Entry count.
   assign count_in = accept ? count_next : count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         read_word_ff <= read_en ? read_bus : '0;
         found_ff     <= found_pos;
         rejected_ff  <= rej;
         rsp_count_ff <= count_next;
         full_ff      <= (count_next == CNT_W'(SLOTS));
         empty_ff     <= (count_next == '0);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_word      = read_word_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.rejected       = rejected_ff;
   assign rsp_chan.entry_count    = rsp_count_ff;
   assign rsp_chan.full_flag      = full_ff;
   assign rsp_chan.empty_flag     = empty_ff;

`ifndef SYNTHESIS
   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("entry count above capacity");

   // An accepted insert that is not refused adds exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && grows && !rej |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add one entry");

   // A refused command leaves the count alone.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      accept && rej |=> $stable(count_ff))
      else $error("refused command changed the count");

   // The reported count matches the held count once the item is shown.
   a_report_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_count_ff == count_ff)
      else $error("reported count differs from held count");

   // The find logic picks at most one cell as the lowest match.
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(lowest_hit))
      else $error("more than one lowest match");
`endif

endmodule

// ===== dv/tb_bounded_array_list_engine_unit.sv =====
// Self-checking testbench of the bounded array list engine with a behavioural list predictor.
module tb_bounded_array_list_engine_unit;
   import blae_pkg::*;

   localparam int ITEM_TARGET  = 600;
   localparam int QUIET_TAIL   = 60;
   localparam int LONG_HOLD    = 80;
   localparam int HOLD_AFTER   = 200;
   localparam int CMD_CODE_MAX = (1 << CMD_W) - 1;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] data_word;
      bit                       drain_first;
   } list_cmd_type;

   typedef struct {
      logic signed [WORD_W-1:0] read_word;
      logic signed [POS_W-1:0]  found_position;
      logic                     rejected;
      logic [CNT_W-1:0]         entry_count;
      logic                     full_flag;
      logic                     empty_flag;
   } list_result_type;

   logic clock;
   logic reset;

   blae_req_if req_chan();
   blae_rsp_if rsp_chan();

   bounded_array_list_engine_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted contents of the list, cleared as the block is on reset.
   logic signed [WORD_W-1:0] model_words [SLOTS] = '{default: '0};
   int                       model_len = 0;

   list_cmd_type             cmds_to_send [$];
   list_result_type          outcomes_due [$];
   list_cmd_type             cmd_on_bus;
   logic signed [WORD_W-1:0] word_pool [8];

   int plan_len    = 0;
   int total_items = 0;
   int sent_count  = 0;
   int seen_count  = 0;
   int gap_left    = 0;
   int stall_left  = 0;
   bit long_hold_done = 1'b0;
   bit mismatch_seen  = 1'b0;

   // Applies one command to the predicted list and returns the result it should give.
   function automatic list_result_type list_step_outcome(list_cmd_type c);
      list_result_type r;
      int           p;
      bit           full;
      bit           empty;
      bit           hit;
      p     = c.position;
      full  = (model_len >= SLOTS);
      empty = (model_len == 0);
      hit   = 1'b0;
      r.read_word      = '0;
      r.found_position = NOT_FOUND;
      r.rejected       = 1'b0;
      case (c.command)
         CMD_GET: begin
            if (p < SLOTS) r.read_word = model_words[p];
            else r.rejected = 1'b1;
         end
         CMD_SET: begin
            if (p < SLOTS) model_words[p] = c.data_word;
            else r.rejected = 1'b1;
         end
         CMD_INS_LAST, CMD_INS_FIRST, CMD_INS_AT: begin
            // Every insert is an insert at some index; later entries move up.
            if (c.command == CMD_INS_LAST) p = model_len;
            else if (c.command == CMD_INS_FIRST) p = 0;
            if (full || p > model_len) begin
               r.rejected = 1'b1;
            end else begin
               for (int i = model_len; i > p; i--) model_words[i] = model_words[i-1];
               model_words[p] = c.data_word;
               model_len++;
            end
         end
         CMD_DEL_LAST, CMD_DEL_FIRST, CMD_DEL_AT: begin
            // Later entries move down; the vacated tail slot keeps its old word.
            if (c.command == CMD_DEL_LAST) p = model_len - 1;
            else if (c.command == CMD_DEL_FIRST) p = 0;
            if (empty || p >= model_len) begin
               r.rejected = 1'b1;
            end else begin
               r.read_word = model_words[p];
               for (int i = p; i + 1 < model_len; i++) model_words[i] = model_words[i+1];
               model_len--;
            end
         end
         CMD_FIND: begin
            // Only entries inside the list take part in the search.
            for (int i = 0; i < model_len; i++) begin
               if (!hit && model_words[i] == c.data_word) begin
                  r.found_position = POS_W'(i);
                  hit = 1'b1;
               end
            end
         end
         default: begin
            r.rejected = 1'b1;
         end
      endcase
      r.entry_count = CNT_W'(model_len);
      r.full_flag   = (model_len >= SLOTS);
      r.empty_flag  = (model_len == 0);
      return r;
   endfunction

   // Queues one command and tracks the list length it will leave behind.
   function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int pos,
                                     logic signed [WORD_W-1:0] word, bit drain);
      list_cmd_type c;
      c.command     = cmd;
      c.position    = POS_W'(pos);
      c.data_word   = word;
      c.drain_first = drain;
      cmds_to_send.push_back(c);
      case (cmd)
         CMD_INS_LAST, CMD_INS_FIRST: begin
            if (plan_len < SLOTS) plan_len++;
         end
         CMD_INS_AT: begin
            if (plan_len < SLOTS && pos <= plan_len) plan_len++;
         end
         CMD_DEL_LAST, CMD_DEL_FIRST: begin
            if (plan_len > 0) plan_len--;
         end
         CMD_DEL_AT: begin
            if (pos < plan_len) plan_len--;
         end
         default: ;
      endcase
   endfunction

   // Half of the words come from a small pool so that searches often hit.
   function automatic logic signed [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   // Idling runs in stretches and stops altogether near the end of the run.
   function automatic bit idling_on(int done);
      return (done < total_items - QUIET_TAIL) && ((done / 50) % 4 != 3);
   endfunction

   function automatic void check_field(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // Clock, reset and known values on every input from the start.
   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_GET;
      req_chan.position    = '0;
      req_chan.data_word   = '0;
      rsp_chan.ready       = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stimulus: a directed opening, then random episodes, then the end of the run.
   initial begin : stimulus
      int pos;
      int extra;
      int kind;
      logic [CMD_W-1:0] cmd;

      word_pool[0] = '0;
      word_pool[1] = WORD_MAX;
      word_pool[2] = WORD_MIN;
      word_pool[3] = -1;
      for (int i = 4; i < 8; i++) word_pool[i] = $urandom();

      // Direct slot access at and beyond capacity, and removals from an empty list.
      queue_cmd(CMD_GET, 0, '0, 1'b0);
      queue_cmd(CMD_GET, POS_MAX, '0, 1'b0);
      queue_cmd(CMD_SET, SLOTS - 1, WORD_MAX, 1'b0);
      queue_cmd(CMD_SET, SLOTS, -1, 1'b0);
      queue_cmd(CMD_DEL_LAST, 0, '0, 1'b0);
      queue_cmd(CMD_DEL_FIRST, 0, '0, 1'b0);
      queue_cmd(CMD_DEL_AT, 0, '0, 1'b0);
      queue_cmd(CMD_INS_AT, 1, '0, 1'b0);
      // A word beyond the list length must not be found.
      queue_cmd(CMD_FIND, 0, WORD_MAX, 1'b0);
      // Build a short list, pausing first until every result is back.
      queue_cmd(CMD_INS_AT, 0, WORD_MIN, 1'b1);
      queue_cmd(CMD_INS_LAST, 0, -1, 1'b0);
      queue_cmd(CMD_INS_FIRST, 0, '0, 1'b0);
      queue_cmd(CMD_INS_AT, 3, WORD_MAX, 1'b0);
      queue_cmd(CMD_FIND, POS_MAX, -1, 1'b0);
      queue_cmd(CMD_FIND, 0, 32'sh12345678, 1'b0);
      queue_cmd(CMD_GET, SLOTS - 1, '0, 1'b0);
      queue_cmd(CMD_DEL_AT, 4, '0, 1'b0);
      queue_cmd(CMD_DEL_AT, 1, '0, 1'b0);
      queue_cmd(CMD_DEL_FIRST, 0, '0, 1'b0);
      queue_cmd(CMD_DEL_LAST, 0, '0, 1'b0);
      queue_cmd(CMD_W'(CMD_FIND + 1), 0, '0, 1'b0);
      queue_cmd(CMD_W'(CMD_CODE_MAX), POS_MAX, -1, 1'b0);
      queue_cmd(CMD_GET, 3, '0, 1'b0);

      // Random episodes: fill to full, drain to empty, mixed traffic and noise.
      while (cmds_to_send.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            extra = $urandom_range(1, 3);
            while (plan_len < SLOTS || extra > 0) begin
               if (plan_len == SLOTS) extra--;
               pos = $urandom_range(0, plan_len);
               case ($urandom_range(0, 4))
                  0: queue_cmd(CMD_INS_LAST, pos, pick_word(), 1'b0);
                  1: queue_cmd(CMD_INS_FIRST, pos, pick_word(), 1'b0);
                  2: queue_cmd(CMD_INS_AT, pos, pick_word(), 1'b0);
                  3: queue_cmd(CMD_FIND, pos, pick_word(), 1'b0);
                  default: queue_cmd(CMD_GET, $urandom_range(0, SLOTS - 1), '0, 1'b0);
               endcase
            end
         end else if (kind < 5) begin
            extra = $urandom_range(1, 2);
            while (plan_len > 0 || extra > 0) begin
               if (plan_len == 0) extra--;
               pos = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
               case ($urandom_range(0, 4))
                  0: queue_cmd(CMD_DEL_LAST, pos, pick_word(), 1'b0);
                  1: queue_cmd(CMD_DEL_FIRST, pos, pick_word(), 1'b0);
                  2: queue_cmd(CMD_DEL_AT, pos, pick_word(), 1'b0);
                  3: queue_cmd(CMD_FIND, pos, pick_word(), 1'b0);
                  default: queue_cmd(CMD_SET, $urandom_range(0, SLOTS - 1), pick_word(), 1'b0);
               endcase
            end
         end else if (kind < 9) begin
            repeat (20) begin
               cmd = CMD_W'($urandom_range(CMD_GET, CMD_FIND));
               case ($urandom_range(0, 3))
                  0: pos = $urandom_range(0, POS_MAX);
                  1: pos = $urandom_range(0, SLOTS - 1);
                  default: pos = $urandom_range(0, plan_len);
               endcase
               queue_cmd(cmd, pos, pick_word(), 1'b0);
            end
         end else begin
            repeat (5) begin
               queue_cmd(CMD_W'($urandom_range(CMD_GET, CMD_CODE_MAX)),
                         $urandom_range(0, POS_MAX), $urandom(), 1'b0);
            end
         end
      end
      cmds_to_send[cmds_to_send.size() / 2].drain_first = 1'b1;
      total_items = cmds_to_send.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item has gone in and every result has come out.
      do @(posedge clock);
      while (cmds_to_send.size() != 0 || req_chan.valid || outcomes_due.size() != 0);
      repeat (20) @(posedge clock);

      if (!mismatch_seen && outcomes_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Driver: offers queued items, predicts each accepted one, inserts random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            outcomes_due.push_back(list_step_outcome(cmd_on_bus));
            sent_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (cmds_to_send.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (cmds_to_send[0].drain_first && outcomes_due.size() != 0) begin
               // Hold this item back until the block has returned everything.
               req_chan.valid <= 1'b0;
            end else if (idling_on(sent_count) && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(0, 5);
               req_chan.valid <= 1'b0;
            end else begin
               cmd_on_bus = cmds_to_send.pop_front();
               req_chan.command   <= cmd_on_bus.command;
               req_chan.position  <= cmd_on_bus.position;
               req_chan.data_word <= cmd_on_bus.data_word;
               req_chan.valid     <= 1'b1;
            end
         end
      end
   end

   // Monitor: checks each accepted result and stalls the result channel at random.
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_count++;
            if (outcomes_due.size() == 0) begin
               $error("result item arrived with no command outstanding");
               mismatch_seen = 1'b1;
            end else begin
               want = outcomes_due.pop_front();
               check_field("read_word", want.read_word, rsp_chan.read_word);
               check_field("found_position", WORD_W'(want.found_position),
                           WORD_W'(rsp_chan.found_position));
               check_field("rejected", WORD_W'(want.rejected), WORD_W'(rsp_chan.rejected));
               check_field("entry_count", WORD_W'(want.entry_count),
                           WORD_W'(rsp_chan.entry_count));
               check_field("full_flag", WORD_W'(want.full_flag), WORD_W'(rsp_chan.full_flag));
               check_field("empty_flag", WORD_W'(want.empty_flag),
                           WORD_W'(rsp_chan.empty_flag));
            end
         end
         // One long hold-off so that the block backs up and stalls its input.
         if (!long_hold_done && seen_count >= HOLD_AFTER) begin
            stall_left     = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on(seen_count) && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
